// File: hdl/cfq_pkg.sv
package cfq_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned QS_W  = 7;
  localparam logic [QS_W-1:0] QS_RESET = 7'd64;
  localparam logic [QS_W-1:0] QS_MIN   = 7'd2;

  localparam logic [1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [1:0] CMD_DEQUEUE = 2'd1;

  typedef enum logic [2:0] {
    ST_ENQUEUED   = 3'd0,
    ST_DROPPED    = 3'd1,
    ST_DEQUEUED   = 3'd2,
    ST_DEQ_EMPTY  = 3'd3,
    ST_SHOWN      = 3'd4,
    ST_SHOW_EMPTY = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_ENQ,
    OP_DEQ,
    OP_SHOW
  } op_kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SHOW
  } state_t;

  typedef struct packed {
    logic [1:0]              command;
    logic signed [KEY_W-1:0] key_in;
  } req_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key_out;
    status_t                 status;
    logic                    last;
  } rsp_t;

  typedef struct packed {
    op_kind_t                kind;
    logic signed [KEY_W-1:0] key;
  } op_t;

endpackage

// File: hdl/cfq_front.sv
module cfq_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  cfq_pkg::req_t req,
  output logic          op_valid,
  input  logic          op_pop,
  output cfq_pkg::op_t  op
);
  import cfq_pkg::*;

  op_t        ent [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  op_t        dec;

  assign req_ready = (cnt != 2'd2);
  assign op_valid  = (cnt != 2'd0);
  assign op        = ent[rd_ptr];
  assign push      = req_valid && req_ready;
  assign pop       = op_pop && op_valid;

  always_comb begin
    dec.key = req.key_in;
    case (req.command)
      CMD_ENQUEUE: dec.kind = OP_ENQ;
      CMD_DEQUEUE: dec.kind = OP_DEQ;
      default:     dec.kind = OP_SHOW;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   cnt <= cnt + 2'd1;
        2'b01:   cnt <= cnt - 2'd1;
        default: cnt <= cnt;
      endcase
    end
  end

endmodule

// File: hdl/cfq_back.sv
module cfq_back #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     op_valid,
  output logic                     op_pop,
  input  cfq_pkg::op_t             op,
  input  logic                     cfg_valid,
  input  logic [cfq_pkg::QS_W-1:0] cfg_data,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output cfq_pkg::rsp_t            rsp
);
  import cfq_pkg::*;

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned NW = PW + 1;
  localparam logic [NW-1:0] N_MAX = NW'(DEPTH);
  localparam logic [NW-1:0] N_MIN = NW'(2);

  function automatic logic [PW-1:0] adv(input logic [PW-1:0] p, input logic [NW-1:0] lim);
    logic [NW-1:0] s;
    s = {1'b0, p} + NW'(1);
    adv = (s >= lim) ? '0 : s[PW-1:0];
  endfunction

  logic signed [KEY_W-1:0] mem [DEPTH];
  logic signed [KEY_W-1:0] rd_data;
  logic [PW-1:0]           rd_addr;

  logic [QS_W-1:0] qs;
  logic [NW-1:0]   n;
  logic [PW-1:0]   head;
  logic [PW-1:0]   tail;
  logic [PW-1:0]   walk;
  logic [PW-1:0]   walk_nx;
  state_t          state;
  state_t          state_next;

  logic empty;
  logic full;
  logic can_load;
  logic ld;
  rsp_t ld_data;
  logic wr_en;
  logic head_adv;
  logic tail_adv;
  logic walk_ld;
  logic walk_adv;

  always_comb begin
    if (qs < QS_MIN) begin
      n = N_MIN;
    end else if (32'(qs) > 32'(DEPTH)) begin
      n = N_MAX;
    end else begin
      n = NW'(qs);
    end
  end

  assign empty    = (head == tail);
  assign full     = (adv(tail, n) == head);
  assign walk_nx  = adv(walk, n);
  assign can_load = !rsp_valid || rsp_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (op_valid && !empty) begin
          if (op.kind == OP_DEQ) begin
            state_next = S_DEQ;
          end else if (op.kind == OP_SHOW) begin
            state_next = S_SHOW;
          end
        end
      end
      S_DEQ: begin
        if (can_load) begin
          state_next = S_IDLE;
        end
      end
      S_SHOW: begin
        if (can_load && walk_nx == tail) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    op_pop   = 1'b0;
    ld       = 1'b0;
    ld_data  = '{key_out: '0, status: ST_ENQUEUED, last: 1'b1};
    wr_en    = 1'b0;
    head_adv = 1'b0;
    tail_adv = 1'b0;
    walk_ld  = 1'b0;
    walk_adv = 1'b0;
    rd_addr  = head;
    case (state)
      S_IDLE: begin
        if (op_valid) begin
          case (op.kind)
            OP_ENQ: begin
              if (can_load) begin
                op_pop = 1'b1;
                ld     = 1'b1;
                if (full) begin
                  ld_data.key_out = op.key;
                  ld_data.status  = ST_DROPPED;
                end else begin
                  wr_en    = 1'b1;
                  tail_adv = 1'b1;
                end
              end
            end
            OP_DEQ: begin
              if (!empty) begin
                op_pop = 1'b1;
              end else if (can_load) begin
                op_pop         = 1'b1;
                ld             = 1'b1;
                ld_data.status = ST_DEQ_EMPTY;
              end
            end
            OP_SHOW: begin
              if (!empty) begin
                op_pop  = 1'b1;
                walk_ld = 1'b1;
              end else if (can_load) begin
                op_pop         = 1'b1;
                ld             = 1'b1;
                ld_data.status = ST_SHOW_EMPTY;
              end
            end
            default: op_pop = 1'b0;
          endcase
        end
      end
      S_DEQ: begin
        if (can_load) begin
          ld              = 1'b1;
          head_adv        = 1'b1;
          ld_data.key_out = rd_data;
          ld_data.status  = ST_DEQUEUED;
        end
      end
      S_SHOW: begin
        rd_addr = walk;
        if (can_load) begin
          ld              = 1'b1;
          walk_adv        = 1'b1;
          rd_addr         = walk_nx;
          ld_data.key_out = rd_data;
          ld_data.status  = ST_SHOWN;
          ld_data.last    = (walk_nx == tail);
        end
      end
      default: ld = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail] <= op.key;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (walk_ld) begin
      walk <= head;
    end else if (walk_adv) begin
      walk <= walk_nx;
    end
    if (ld) begin
      rsp <= ld_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qs        <= QS_RESET;
      head      <= '0;
      tail      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= ld || (rsp_valid && !rsp_ready);
      if (cfg_valid) begin
        qs   <= cfg_data;
        head <= '0;
        tail <= '0;
      end else begin
        if (head_adv) begin
          head <= adv(head, n);
        end
        if (tail_adv) begin
          tail <= adv(tail, n);
        end
      end
    end
  end

  a_ptr_in_ring: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, head} < n) && ({1'b0, tail} < n))
    else $error("queue pointer outside ring");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !full)
    else $error("enqueue write into full ring");

  a_deq_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DEQ && !can_load && !cfg_valid) |=> (state == S_DEQ) && $stable(head))
    else $error("dequeue lost while output stalled");

  a_show_ends_last: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHOW && state_next == S_IDLE) |-> (ld && ld_data.last))
    else $error("show walk ended without last result");

endmodule

// File: hdl/circular_fifo_queue.sv
// Circular FIFO of signed 32-bit keys.
// req channel: command (enqueue, dequeue, show) plus key_in, valid/ready.
// rsp channel: key_out, status, last, valid/ready; last marks the final
// result of one request. cfg channel: writes the ring size (2..DEPTH slots,
// values outside are clamped) and empties the queue; write only when idle.
// Requests enter a two-entry command queue; the back end executes them
// against a ring memory (one write port, one read port) with registered
// read data. Results are held in the output register; a dequeue with a
// key or a show of a non-empty queue first reads the ring memory.
// Steps: enqueue and empty-queue commands finish in S_IDLE; a dequeue
// reads memory in S_IDLE, then outputs in S_DEQ; show reads the first key
// in S_IDLE, then one key per cycle in S_SHOW while the receiver is ready.
// Reset: queue empty, ring size 64 slots; stored keys are not cleared.
// Receiver stall: the result is held in the output register, the back end
// waits, and the command queue keeps taking up to two requests.
module circular_fifo_queue #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     req_valid,
  output logic                     req_ready,
  input  cfq_pkg::req_t            req,
  output logic                     rsp_valid,
  input  logic                     rsp_ready,
  output cfq_pkg::rsp_t            rsp,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [cfq_pkg::QS_W-1:0] cfg_data
);
  import cfq_pkg::*;

  logic op_valid;
  logic op_pop;
  op_t  op;

  assign cfg_ready = 1'b1;

  cfq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .op        (op)
  );

  cfq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (op_valid),
    .op_pop    (op_pop),
    .op        (op),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// File: test/circular_fifo_queue_tb.sv
`timescale 1ns / 100ps

import cfq_pkg::*;

class queue_mirror #(int unsigned DEPTH = 64);
  logic signed [KEY_W-1:0] ring [DEPTH];
  int unsigned head_ptr;
  int unsigned tail_ptr;
  logic [QS_W-1:0] slots_reg;
  rsp_t awaited[$];
  int errors;

  function new();
    head_ptr = 0;
    tail_ptr = 0;
    slots_reg = QS_RESET;
    errors = 0;
  endfunction

  function int unsigned ring_len();
    if (slots_reg < QS_MIN) return 32'(QS_MIN);
    if (32'(slots_reg) > DEPTH) return DEPTH;
    return 32'(slots_reg);
  endfunction

  function int unsigned step_ptr(int unsigned p, int unsigned n);
    return (p + 1 >= n) ? 0 : p + 1;
  endfunction

  function void set_slots(logic [QS_W-1:0] v);
    slots_reg = v;
    head_ptr = 0;
    tail_ptr = 0;
  endfunction

  function void apply_request(req_t r);
    int unsigned n;
    int unsigned h;
    int unsigned t;
    int unsigned nt;
    rsp_t e;
    n = ring_len();
    h = head_ptr % n;
    t = tail_ptr % n;
    e.key_out = '0;
    e.last = 1'b1;
    if (r.command == CMD_ENQUEUE) begin
      nt = step_ptr(t, n);
      if (nt == h) begin
        e.key_out = r.key_in;
        e.status = ST_DROPPED;
      end else begin
        ring[t] = r.key_in;
        tail_ptr = nt;
        e.status = ST_ENQUEUED;
      end
      awaited.push_back(e);
    end else if (r.command == CMD_DEQUEUE) begin
      if (h == t) begin
        e.status = ST_DEQ_EMPTY;
      end else begin
        e.key_out = ring[h];
        e.status = ST_DEQUEUED;
        head_ptr = step_ptr(h, n);
      end
      awaited.push_back(e);
    end else if (h == t) begin
      e.status = ST_SHOW_EMPTY;
      awaited.push_back(e);
    end else begin
      // show walks head to tail without touching the pointers
      while (h != t) begin
        nt = step_ptr(h, n);
        e.key_out = ring[h];
        e.status = ST_SHOWN;
        e.last = (nt == t);
        awaited.push_back(e);
        h = nt;
      end
    end
  endfunction

  function void match_result(rsp_t got);
    rsp_t e;
    if (awaited.size() == 0) begin
      $error("unexpected result: key_out %0d status %0d last %0d",
             got.key_out, got.status, got.last);
      errors++;
      return;
    end
    e = awaited.pop_front();
    if (got.key_out !== e.key_out) begin
      $error("key_out expected %0d actual %0d", e.key_out, got.key_out);
      errors++;
    end
    if (got.status !== e.status) begin
      $error("status expected %0d actual %0d", e.status, got.status);
      errors++;
    end
    if (got.last !== e.last) begin
      $error("last expected %0d actual %0d", e.last, got.last);
      errors++;
    end
  endfunction
endclass

module circular_fifo_queue_tb;

  localparam int unsigned RING_DEPTH = 64;
  localparam logic [1:0] CMD_SHOW     = 2'd2;
  localparam logic [1:0] CMD_SHOW_ALT = 2'd3;
  localparam int unsigned PHASE_ITEMS = 49;

  logic            clk;
  logic            rst;
  logic            req_valid;
  logic            req_ready;
  req_t            req;
  logic            rsp_valid;
  logic            rsp_ready;
  rsp_t            rsp;
  logic            cfg_valid;
  logic            cfg_ready;
  logic [QS_W-1:0] cfg_data;

  queue_mirror #(RING_DEPTH) mirror;
  int unsigned rsp_stall_pct;
  int unsigned hold_left;

  circular_fifo_queue #(.DEPTH(RING_DEPTH)) uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("circular_fifo_queue regression: fail");
    $finish;
  end

  // result side: sample at the edge, then pick ready for the next cycle
  initial begin
    rsp_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && rsp_ready) mirror.match_result(rsp);
      if (hold_left > 0) begin
        hold_left--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
    end
  end

  function automatic req_t make_req(logic [1:0] cmd, logic signed [KEY_W-1:0] key);
    req_t r;
    r.command = cmd;
    r.key_in = key;
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_request(input req_t r, input int unsigned gap_pct);
    while ($urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    do @(posedge clk); while (!req_ready);
    mirror.apply_request(r);
  endtask

  task automatic wait_results_drained();
    req_valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_ring_size(input logic [QS_W-1:0] v);
    wait_results_drained();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mirror.set_slots(v);
  endtask

  task automatic random_phase(input int unsigned gap_pct);
    int unsigned i;
    int unsigned roll;
    bit fill_mode;
    logic [1:0] cmd;
    fill_mode = 1'b1;
    for (i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 16 == 0) fill_mode = $urandom_range(0, 2) != 0;
      roll = $urandom_range(0, 99);
      if (roll < (fill_mode ? 70 : 20)) cmd = CMD_ENQUEUE;
      else if (roll < 85) cmd = CMD_DEQUEUE;
      else cmd = $urandom_range(0, 1) ? CMD_SHOW : CMD_SHOW_ALT;
      offer_request(make_req(cmd, pick_key()), gap_pct);
    end
  endtask

  int unsigned send_gap [4] = '{0, 51, 0, 23};
  int unsigned recv_gap [4] = '{0, 0, 51, 23};
  int unsigned ph;
  int unsigned k;
  logic [QS_W-1:0] phase_slots [4];

  initial begin
    mirror = new();
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rsp_stall_pct = 0;
    hold_left = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty queue, key extremes, both show encodings, drain to empty
    offer_request(make_req(CMD_DEQUEUE, 32'h1234_5678), 0);
    offer_request(make_req(CMD_SHOW, 0), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'h8000_0000), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'h7FFF_FFFF), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'hFFFF_FFFF), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'h0000_0000), 0);
    offer_request(make_req(CMD_SHOW, 0), 0);
    offer_request(make_req(CMD_SHOW_ALT, 32'hFFFF_FFFF), 0);
    for (k = 0; k < 4; k++) offer_request(make_req(CMD_DEQUEUE, 0), 0);
    offer_request(make_req(CMD_DEQUEUE, 0), 0);

    // smallest ring: one usable slot, full drops
    write_ring_size(QS_MIN);
    offer_request(make_req(CMD_ENQUEUE, 32'd5), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'd6), 0);
    offer_request(make_req(CMD_SHOW, 0), 0);
    offer_request(make_req(CMD_DEQUEUE, 0), 0);
    offer_request(make_req(CMD_DEQUEUE, 0), 0);

    // below range clamps to the minimum
    write_ring_size(7'd0);
    offer_request(make_req(CMD_ENQUEUE, 32'h5555_5555), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'hAAAA_AAAA), 0);

    // above range clamps to DEPTH; the write empties the queue
    write_ring_size(7'd127);
    offer_request(make_req(CMD_SHOW, 0), 0);
    offer_request(make_req(CMD_ENQUEUE, 32'd1), 0);
    write_ring_size(7'd65);
    offer_request(make_req(CMD_SHOW_ALT, 0), 0);
    offer_request(make_req(CMD_ENQUEUE, -32'sd7), 0);
    offer_request(make_req(CMD_SHOW, 0), 0);

    // receiver holds off while requests keep coming, block backs up
    write_ring_size(7'd64);
    hold_left = 300;
    for (k = 0; k < 40; k++) offer_request(make_req(CMD_ENQUEUE, $urandom), 0);
    offer_request(make_req(CMD_SHOW, 0), 0);

    write_ring_size(7'd1);
    phase_slots[0] = 7'd4;
    phase_slots[1] = 7'd64;
    phase_slots[2] = 7'($urandom_range(2, 64));
    phase_slots[3] = 7'd3;
    for (ph = 0; ph < 4; ph++) begin
      write_ring_size(phase_slots[ph]);
      rsp_stall_pct = recv_gap[ph];
      random_phase(send_gap[ph]);
    end

    wait_results_drained();
    repeat (10) @(posedge clk);
    if (mirror.errors == 0) begin
      $display("circular_fifo_queue regression: pass");
    end else begin
      $display("circular_fifo_queue regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/cfq_pkg.sv
hdl/cfq_front.sv
hdl/cfq_back.sv
hdl/circular_fifo_queue.sv
test/circular_fifo_queue_tb.sv
